// ----- design/floppy35_drive_control_query_defines.svh -----
// Assertion macros shared by the drive control query design.
`ifndef FLOPPY35_DRIVE_CONTROL_QUERY_DEFINES_SVH
`define FLOPPY35_DRIVE_CONTROL_QUERY_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on the rising clock, quiet while reset is asserted.
`define FDCQ_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that an antecedent implies a consequent on the following clock.
`define FDCQ_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define FDCQ_ASSERT(name, prop, msg)
`define FDCQ_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

// ----- design/fdcq_pkg.sv -----
// Package: state, configuration types and command codes of the drive control query.
`default_nettype none

package fdcq_pkg;

  // Architectural drive state
  typedef struct packed {
    logic       strobe_seen;
    logic       step_inward;
    logic       ejected;
    logic       ejecting;
    logic       upper_head;
    logic       spindle_on;
    logic [7:0] head_track;
    logic       sense_level;
  } state_t;

  // Configuration registers
  typedef struct packed {
    logic disk_present;
    logic write_protected;
    logic double_sided;
  } cfg_t;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgDiskPresent    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgWriteProtected = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgDoubleSided    = 2'd2;

  // Control codes (executed on the first low strobe sample)
  localparam logic [3:0] CtlDirInward  = 4'h0;
  localparam logic [3:0] CtlDirOutward = 4'h1;
  localparam logic [3:0] CtlClearEject = 4'h3;
  localparam logic [3:0] CtlStep       = 4'h4;
  localparam logic [3:0] CtlMotorOn    = 4'h8;
  localparam logic [3:0] CtlMotorOff   = 4'h9;
  localparam logic [3:0] CtlEject      = 4'hD;

  // Status query codes
  localparam logic [3:0] QryNotInward   = 4'h0;
  localparam logic [3:0] QryLowerHead   = 4'h1;
  localparam logic [3:0] QryNoDisk      = 4'h2;
  localparam logic [3:0] QryUpperHead   = 4'h3;
  localparam logic [3:0] QryStepReady   = 4'h4;
  localparam logic [3:0] QryWriteEnable = 4'h6;
  localparam logic [3:0] QryMotorOff    = 4'h8;
  localparam logic [3:0] QrySides       = 4'h9;
  localparam logic [3:0] QryNotTrack0   = 4'hA;
  localparam logic [3:0] QryReadReady   = 4'hB;
  localparam logic [3:0] QryEjected     = 4'hC;
  localparam logic [3:0] QryInstalled   = 4'hF;

  // Tracks moved by one step command
  localparam logic [7:0] StepSize = 8'd2;

endpackage

`default_nettype wire

// ----- design/fdcq_in_if.sv -----
// Interface: input sample channel (select lines, strobe, ready level).
`default_nettype none

interface fdcq_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] command;
  logic       strobe_req;
  logic       head_ready;

  modport source (output valid, command, strobe_req, head_ready, input ready);
  modport sink   (input valid, command, strobe_req, head_ready, output ready);
endinterface

`default_nettype wire

// ----- design/fdcq_out_if.sv -----
// Interface: result channel (sense level and drive status).
`default_nettype none

interface fdcq_out_if;
  logic       valid;
  logic       ready;
  logic       sense;
  logic [7:0] track;
  logic       motor_running;
  logic       upper_selected;
  logic       disk_switched;
  logic       eject_pending;
  logic       inward_dir;

  modport source (output valid, sense, track, motor_running, upper_selected,
                  disk_switched, eject_pending, inward_dir, input ready);
  modport sink   (input valid, sense, track, motor_running, upper_selected,
                  disk_switched, eject_pending, inward_dir, output ready);
endinterface

`default_nettype wire

// ----- design/fdcq_exec.sv -----
// Next-state logic: strobe tracking, control command execution, status queries.
`default_nettype none

module fdcq_exec import fdcq_pkg::*; #(
  parameter int unsigned TrackCount = 160
) (
  input  state_t     state_i,
  input  cfg_t       cfg_i,
  input  logic [3:0] command_i,
  input  logic       strobe_i,
  input  logic       ready_i,
  output state_t     state_o
);

  // Highest track from which an inward step is still allowed (exclusive)
  localparam logic [7:0] StepInLimit = 8'(TrackCount - 2);

  always_comb begin
    state_o = state_i;
    if (strobe_i) begin
      // Remember the strobe; execute on the first low sample
      state_o.strobe_seen = 1'b1;
    end else if (state_i.strobe_seen) begin
      state_o.strobe_seen = 1'b0;
      unique case (command_i)
        CtlDirInward:  state_o.step_inward = 1'b1;
        CtlDirOutward: state_o.step_inward = 1'b0;
        CtlClearEject: state_o.ejected     = 1'b0;
        CtlStep: begin
          // A pending eject completes instead of moving the head
          if (state_i.ejecting) begin
            state_o.ejecting = 1'b0;
            state_o.ejected  = 1'b1;
          end else if (state_i.step_inward) begin
            if (state_i.head_track < StepInLimit) begin
              state_o.head_track = state_i.head_track + StepSize;
            end
          end else if (state_i.head_track >= StepSize) begin
            state_o.head_track = state_i.head_track - StepSize;
          end
        end
        CtlMotorOn:  state_o.spindle_on = 1'b1;
        CtlMotorOff: state_o.spindle_on = 1'b0;
        CtlEject: begin
          if (!state_i.ejecting) begin
            state_o.spindle_on = 1'b0;
            state_o.ejecting   = 1'b1;
          end
        end
        default: ;
      endcase
    end else begin
      // Status query; head selects move the track by one
      unique case (command_i)
        QryNotInward:   state_o.sense_level = ~state_i.step_inward;
        QryNoDisk:      state_o.sense_level = ~cfg_i.disk_present;
        QryStepReady:   state_o.sense_level = ready_i;
        QryWriteEnable: state_o.sense_level = cfg_i.disk_present & ~cfg_i.write_protected;
        QryMotorOff:    state_o.sense_level = ~state_i.spindle_on;
        QryNotTrack0:   state_o.sense_level = (state_i.head_track != 8'd0);
        QryEjected:     state_o.sense_level = state_i.ejected;
        QrySides:       state_o.sense_level = cfg_i.double_sided;
        QryReadReady:   state_o.sense_level = ready_i;
        QryInstalled:   state_o.sense_level = 1'b0;
        QryLowerHead: begin
          if (state_i.upper_head) begin
            state_o.head_track = state_i.head_track - 8'd1;
            state_o.upper_head = 1'b0;
          end
        end
        QryUpperHead: begin
          if (!state_i.upper_head) begin
            state_o.head_track = state_i.head_track + 8'd1;
            state_o.upper_head = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- design/floppy35_drive_control_query.sv -----
// Top level: drive control query with input register, state and result register.
//
//  channel   dir  handshake     words
//  sample_i  in   valid/ready   command[3:0], strobe_req, head_ready
//  result_o  out  valid/ready   sense, track[7:0], status flags
//  cfg       in   cfg_we_i      cfg_idx_i[1:0], cfg_wdata_i[0]
//
// One word per cycle while the result is not stalled; an accepted word passes
// the input register, then next-state logic into the result register.
// Reset clears the drive state, configuration and both valid flags.
// A stalled result holds; the input register keeps accepting as long as the
// result register is empty or being drained in the same cycle.
`default_nettype none

`include "floppy35_drive_control_query_defines.svh"

module floppy35_drive_control_query import fdcq_pkg::*; #(
  parameter int unsigned TrackCount = 160
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  fdcq_in_if.sink             sample_i,
  fdcq_out_if.source          result_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [0:0]          cfg_wdata_i
);

  cfg_t       cfg_q;
  state_t     state_q, state_d;
  logic       s1_valid_q;
  logic [3:0] s1_command_q;
  logic       s1_strobe_q;
  logic       s1_ready_q;
  logic       out_valid_q;
  state_t     out_q;
  logic       out_free;
  logic       s1_adv;

  // Handshake between the stages
  assign out_free       = !out_valid_q || result_o.ready;
  assign s1_adv         = s1_valid_q && out_free;
  assign sample_i.ready = !s1_valid_q || out_free;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgDiskPresent:    cfg_q.disk_present    <= cfg_wdata_i[0];
        CfgWriteProtected: cfg_q.write_protected <= cfg_wdata_i[0];
        CfgDoubleSided:    cfg_q.double_sided    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Capture the input word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (sample_i.ready) begin
      s1_valid_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_i.ready && sample_i.valid) begin
      s1_command_q <= sample_i.command;
      s1_strobe_q  <= sample_i.strobe_req;
      s1_ready_q   <= sample_i.head_ready;
    end
  end

  fdcq_exec #(
    .TrackCount (TrackCount)
  ) u_exec (
    .state_i   (state_q),
    .cfg_i     (cfg_q),
    .command_i (s1_command_q),
    .strobe_i  (s1_strobe_q),
    .ready_i   (s1_ready_q),
    .state_o   (state_d)
  );

  // Advance drive state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        state_q <= state_d;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Hold the result word
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q <= state_d;
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.sense          = out_q.sense_level;
  assign result_o.track          = out_q.head_track;
  assign result_o.motor_running  = out_q.spindle_on;
  assign result_o.upper_selected = out_q.upper_head;
  assign result_o.disk_switched  = out_q.ejected;
  assign result_o.eject_pending  = out_q.ejecting;
  assign result_o.inward_dir     = out_q.step_inward;

  // Track parity always follows the selected head
  `FDCQ_ASSERT(a_track_parity, state_q.head_track[0] == state_q.upper_head, "track parity and head disagree")
  // Starting an eject stops the motor
  `FDCQ_ASSERT(a_eject_stops_motor, !($rose(state_q.ejecting) && state_q.spindle_on), "motor on at eject start")
  // A strobe-high word only marks the strobe and leaves the sense level alone
  `FDCQ_ASSERT_NEXT(a_strobe_hold, s1_adv && s1_strobe_q, state_q.strobe_seen && $stable(state_q.sense_level), "strobe word changed sense")

endmodule

`default_nettype wire
